>>> sv/tws_pkg.sv
`default_nettype none
package tws_pkg;

  localparam int unsigned RESET_CLOCKS_DEF = 9;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_HOLD = 1'b0,
    CFG_LONG_HOLD  = 1'b1
  } tws_cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_CONN_RESET = 2'd0,
    MODE_START      = 2'd1,
    MODE_WRITE      = 2'd2,
    MODE_READ       = 2'd3
  } tws_mode_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       ack_flag;
    logic       data_line;
  } tws_item_t;

  typedef struct packed {
    logic [7:0] short_hold;
    logic [7:0] long_hold;
  } tws_cfg_t;

  typedef struct packed {
    logic       clock_out;
    logic       data_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } tws_res_t;

endpackage
`default_nettype wire

>>> sv/tws_if.sv
`default_nettype none
interface tws_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] mode;
  logic [7:0] tx_byte;
  logic       ack_flag;
  logic       data_line;

  modport source (output valid, cmd_valid, mode, tx_byte, ack_flag, data_line,
                  input ready);
  modport sink   (input valid, cmd_valid, mode, tx_byte, ack_flag, data_line,
                  output ready);
endinterface

interface tws_res_if;
  logic       valid;
  logic       ready;
  logic       clock_out;
  logic       data_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       no_ack;

  modport source (output valid, clock_out, data_pull_low, busy_res, done_res, rx_byte,
                  no_ack, input ready);
  modport sink   (input valid, clock_out, data_pull_low, busy_res, done_res, rx_byte,
                  no_ack, output ready);
endinterface
`default_nettype wire

>>> sv/two_wire_sensor_bus_master.sv
// Bit-level master for a two-wire humidity sensor bus.
// item_i carries one timing tick per word: a command (connection reset, start,
// write byte, read byte) with its byte and ack flag, plus the sampled data wire.
// A command is taken only when no transaction is in progress; otherwise ignored.
// result_o returns one word per tick: clock level, data pull-down, busy, done,
// last read byte and the no-ack flag of the last write.
// Hold lengths of the short and long waveform steps come from two registers
// written on cfg_we_i / cfg_idx_i / cfg_wdata_i (0 short, 1 long; 0 acts as 1).
// Throughput is one tick per cycle while result_o is not stalled: the step
// sequencer updates its whole state between the tick register and the result register.
// Each tick passes through the tick register and then the result register
// before its result word appears on result_o.
// A stalled result_o holds its word; item_i.ready drops while the tick register
// is full and the result register is stalled, and stays low until the result is taken.
// Reset clears the sequencer to idle, levels low and released, rx byte zero,
// hold registers to 1 and 5 ticks.
`default_nettype none
module two_wire_sensor_bus_master #(
  parameter int unsigned RESET_CLOCKS = tws_pkg::RESET_CLOCKS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tws_in_if.sink                              item_i,
  tws_res_if.source                           result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tws_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tws_pkg::*;

  logic      in_valid_q;
  tws_item_t in_item_q;
  logic      out_valid_q;
  tws_res_t  out_res_q;
  tws_res_t  res;
  tws_cfg_t  cfg_q;
  logic      advance;

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_hold <= 8'd1;
      cfg_q.long_hold  <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHORT_HOLD: cfg_q.short_hold <= cfg_wdata_i;
        CFG_LONG_HOLD:  cfg_q.long_hold  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) in_valid_q <= item_i.valid;
      if (advance) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_item_q.cmd_valid <= item_i.cmd_valid;
      in_item_q.mode      <= item_i.mode;
      in_item_q.tx_byte   <= item_i.tx_byte;
      in_item_q.ack_flag  <= item_i.ack_flag;
      in_item_q.data_line <= item_i.data_line;
    end
    if (advance) out_res_q <= res;
  end

  tws_step #(
    .RESET_CLOCKS(RESET_CLOCKS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign result_o.valid         = out_valid_q;
  assign result_o.clock_out     = out_res_q.clock_out;
  assign result_o.data_pull_low = out_res_q.data_pull_low;
  assign result_o.busy_res      = out_res_q.busy_res;
  assign result_o.done_res      = out_res_q.done_res;
  assign result_o.rx_byte       = out_res_q.rx_byte;
  assign result_o.no_ack        = out_res_q.no_ack;

endmodule
`default_nettype wire

>>> sv/tws_step.sv
`default_nettype none
module tws_step #(
  parameter int unsigned RESET_CLOCKS = tws_pkg::RESET_CLOCKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire tws_pkg::tws_item_t item_i,
  input  wire tws_pkg::tws_cfg_t  cfg_i,
  output tws_pkg::tws_res_t       res_o
);
  import tws_pkg::*;

  localparam int unsigned IdxWRaw = $clog2(2 * RESET_CLOCKS + 2);
  localparam int unsigned IdxW    = (IdxWRaw > 3) ? IdxWRaw : 3;
  localparam logic [IdxW-1:0] ResetLast = IdxW'(2 * RESET_CLOCKS + 1);

  typedef struct packed {
    logic       clk;
    logic       pull;
    logic [7:0] hold;
    logic       fin;
    logic       load_rx;
  } apply_t;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      hold_q, hold_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic [1:0]      mode_q, mode_d;
  logic            ack_q, ack_d;
  logic            noack_q, noack_d;
  logic            clk_q, clk_d;
  logic            pull_q, pull_d;
  logic [7:0]      rx_q, rx_d;
  logic            done;
  logic [7:0]      hs, hl;
  apply_t          ap;

  // levels and hold of the step at index i
  function automatic apply_t apply_step(input logic [1:0] m, input logic [IdxW-1:0] i,
                                        input logic [7:0] sh, input logic ack,
                                        input logic pull_in, input logic [7:0] h_s,
                                        input logic [7:0] h_l);
    apply_t a;
    a = '{clk: 1'b0, pull: 1'b0, hold: 8'd1, fin: 1'b0, load_rx: 1'b0};
    case (m)
      MODE_CONN_RESET: begin
        if (i > IdxW'(1) && !i[0]) begin
          a.clk  = 1'b1;
          a.hold = h_s;
        end
      end
      MODE_START: begin
        a.hold = h_s;
        case (i)
          IdxW'(1): ;
          IdxW'(2): a.clk = 1'b1;
          IdxW'(3): begin a.clk = 1'b1; a.pull = 1'b1; end
          IdxW'(4): begin a.pull = 1'b1; a.hold = h_l; end
          IdxW'(5): begin a.clk = 1'b1; a.pull = 1'b1; end
          IdxW'(6): a.clk = 1'b1;
          default: begin a.fin = 1'b1; a.hold = 8'd0; end
        endcase
      end
      MODE_WRITE: begin
        case (i)
          IdxW'(1): a.pull = ~sh[7];
          IdxW'(2): begin a.clk = 1'b1; a.pull = pull_in; a.hold = h_l; end
          IdxW'(3): ;
          IdxW'(4): a.clk = 1'b1;
          default: begin a.fin = 1'b1; a.hold = 8'd0; end
        endcase
      end
      default: begin
        case (i)
          IdxW'(1), IdxW'(3): ;
          IdxW'(2): a.clk = 1'b1;
          IdxW'(4): a.pull = ack;
          IdxW'(5): begin a.clk = 1'b1; a.pull = ack; a.hold = h_l; end
          default: begin a.fin = 1'b1; a.hold = 8'd0; a.load_rx = 1'b1; end
        endcase
      end
    endcase
    return a;
  endfunction

  assign hs = (cfg_i.short_hold == 8'd0) ? 8'd1 : cfg_i.short_hold;
  assign hl = (cfg_i.long_hold == 8'd0) ? 8'd1 : cfg_i.long_hold;

  always_comb begin
    idx_d   = idx_q;
    hold_d  = hold_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    mode_d  = mode_q;
    ack_d   = ack_q;
    noack_d = noack_q;
    clk_d   = clk_q;
    pull_d  = pull_q;
    rx_d    = rx_q;
    done    = 1'b0;
    ap      = '0;
    if (en_i) begin
      if (idx_q == '0) begin
        if (item_i.cmd_valid) begin
          mode_d  = item_i.mode;
          idx_d   = IdxW'(1);
          bit_d   = 4'd0;
          shift_d = (item_i.mode == MODE_WRITE) ? item_i.tx_byte : 8'd0;
          ack_d   = item_i.ack_flag;
          ap      = apply_step(mode_d, idx_d, shift_d, ack_d, pull_q, hs, hl);
          clk_d   = ap.clk;
          pull_d  = ap.pull;
          hold_d  = ap.hold;
        end
      end else if (hold_q > 8'd1) begin
        hold_d = hold_q - 8'd1;
      end else begin
        // end of the current step
        case (mode_q)
          MODE_CONN_RESET: begin
            if (idx_q >= ResetLast) begin
              mode_d = MODE_START;
              idx_d  = IdxW'(1);
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          MODE_START: idx_d = idx_q + IdxW'(1);
          MODE_WRITE: begin
            if (idx_q == IdxW'(2)) begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 4'd1;
              idx_d   = (bit_d < 4'd8) ? IdxW'(1) : IdxW'(3);
            end else begin
              if (idx_q == IdxW'(4)) noack_d = item_i.data_line;
              idx_d = idx_q + IdxW'(1);
            end
          end
          default: begin
            if (idx_q == IdxW'(2)) begin
              shift_d = {shift_q[6:0], item_i.data_line};
              bit_d   = bit_q + 4'd1;
              idx_d   = IdxW'(3);
            end else if (idx_q == IdxW'(3)) begin
              idx_d = (bit_q < 4'd8) ? IdxW'(2) : IdxW'(4);
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
        endcase
        ap     = apply_step(mode_d, idx_d, shift_d, ack_q, pull_q, hs, hl);
        clk_d  = ap.clk;
        pull_d = ap.pull;
        hold_d = ap.hold;
        if (ap.load_rx) rx_d = shift_d;
        if (ap.fin) begin
          idx_d = '0;
          done  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      hold_q  <= 8'd0;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      mode_q  <= MODE_CONN_RESET;
      ack_q   <= 1'b0;
      noack_q <= 1'b0;
      clk_q   <= 1'b0;
      pull_q  <= 1'b0;
      rx_q    <= 8'd0;
    end else begin
      idx_q   <= idx_d;
      hold_q  <= hold_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      mode_q  <= mode_d;
      ack_q   <= ack_d;
      noack_q <= noack_d;
      clk_q   <= clk_d;
      pull_q  <= pull_d;
      rx_q    <= rx_d;
    end
  end

  assign res_o.clock_out     = clk_d;
  assign res_o.data_pull_low = pull_d;
  assign res_o.busy_res      = (idx_d != '0);
  assign res_o.done_res      = done;
  assign res_o.rx_byte       = rx_d;
  assign res_o.no_ack        = noack_d;

endmodule
`default_nettype wire

>>> sv/tws_checker.sv
`default_nettype none
module tws_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       clock_out,
  input wire logic       data_pull_low,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] rx_byte,
  input wire logic       no_ack
);

  // stalled result word holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(clock_out) &&
      $stable(data_pull_low) && $stable(busy_res) && $stable(done_res) &&
      $stable(rx_byte) && $stable(no_ack))
    else $error("result word changed while stalled");

  // finishing tick is never busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && done_res |-> !busy_res)
    else $error("done word shows busy");

  // idle bus: clock low, data released
  a_idle_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !busy_res |-> !clock_out && !data_pull_low)
    else $error("bus levels not at rest while idle");

endmodule

bind two_wire_sensor_bus_master tws_checker u_tws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid     (result_o.valid),
  .res_ready     (result_o.ready),
  .clock_out     (result_o.clock_out),
  .data_pull_low (result_o.data_pull_low),
  .busy_res      (result_o.busy_res),
  .done_res      (result_o.done_res),
  .rx_byte       (result_o.rx_byte),
  .no_ack        (result_o.no_ack)
);
`default_nettype wire
